// ===== rtl/core/scfla_pkg.sv =====
// ----------------------------------------------------------------------------
// scfla_pkg: shared types for the size class free list allocator
// Result codes, request kinds and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scfla_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADSIZE = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clear_step;  // clear one class head entry
    logic    load;        // capture the accepted request
    logic    cls_rd;      // read the class head entry
    logic    free_wr;     // push the freed block onto its class list
    logic    take_head;   // pop target is the current list head
    logic    count_init;  // start sizing a fresh chunk
    logic    count_step;  // add one more node to the chunk
    logic    carve_start; // bump the arena top and start linking nodes
    logic    link_wr;     // write the link of one carved node
    logic    link_rd;     // read the link of the block being popped
    logic    pop_wr;      // advance the class head past the popped block
    logic    set_code;    // record the result code
    status_e code;
    logic    res_load;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic bad_size;
    logic is_free;
    logic free_in_arena;
    logic head_valid;
    logic count_done;
    logic fits;
    logic last_node;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/size_class_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_unit: segregated free list block allocator
// Serves allocate and free requests for small blocks out of a byte arena,
// with one LIFO free list per 8-byte size class and chunk refill on demand.
// ----------------------------------------------------------------------------
// Each input word is one request. An allocate pops the head of the list for
// size class (request_bytes-1)/ALIGN_BYTES and returns its byte address; when
// that list is empty a fresh chunk of min(CHUNK_LIMIT_BYTES/node,
// NODES_PER_CHUNK) nodes (at least one) is first carved from the arena bump
// pointer and every node is linked into the list. A free pushes the block
// onto its class list without any check; frees beyond the arena are dropped
// with status ok. Sizes of 0 or above NUM_CLASSES*ALIGN_BYTES return status 2
// and change nothing, and a chunk that does not fit whole returns status 1.
// Every request gives exactly one result word. Requests are handled one at a
// time by a sequencer. An allocate that refills first sizes the chunk one
// node per cycle with an add-and-compare unit and then links it one node per
// cycle through the single write port of the link memory. The load of the
// result register waits while an earlier result is still held there and not
// taken. The next request is taken while a result still waits in the output
// register. After reset the block sweeps the class head memory, one class per
// cycle, so it accepts nothing until the sweep is done.
// ALIGN_BYTES and NUM_CLASSES must be powers of two.
`default_nettype none

module size_class_free_list_allocator_unit #(
  parameter int ALIGN_BYTES       = 8,
  parameter int NODES_PER_CHUNK   = 64,
  parameter int CHUNK_LIMIT_BYTES = 16385,
  parameter int NUM_CLASSES       = 2048,
  parameter int ARENA_BYTES       = 1048576
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request words.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [15:0] request_bytes, [35:16] block_address
  input  wire logic [0:0]  s_axis_tuser,  // [0] operation: 0 allocate, 1 free
  // Result words.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // [19:0] granted_address, [21:20] status
);

  scfla_pkg::cmd_t  cmd;
  scfla_pkg::stat_t stat;
  logic [19:0]      res_grant;
  logic [1:0]       res_status;

  // The sequencer decides what happens in each cycle; the datapath owns all
  // storage and arithmetic and reports the conditions the sequencer needs.
  scfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  scfla_dp #(
    .ALIGN_BYTES       (ALIGN_BYTES),
    .NODES_PER_CHUNK   (NODES_PER_CHUNK),
    .CHUNK_LIMIT_BYTES (CHUNK_LIMIT_BYTES),
    .NUM_CLASSES       (NUM_CLASSES),
    .ARENA_BYTES       (ARENA_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_op_i     (s_axis_tuser[0]),
    .req_bytes_i  (s_axis_tdata[15:0]),
    .req_addr_i   (s_axis_tdata[35:16]),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_grant_o  (res_grant),
    .res_status_o (res_status)
  );

  assign m_axis_tdata = {2'b00, res_status, res_grant};

  // A request is never followed by another in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted in back-to-back cycles");

  // Error results never carry an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[21:20] != scfla_pkg::ST_OK)
    |-> (m_axis_tdata[19:0] == 20'd0))
    else $error("error result carries a nonzero address");

  // Only the three defined result codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[21:20] == scfla_pkg::ST_OK
                       || m_axis_tdata[21:20] == scfla_pkg::ST_NOMEM
                       || m_axis_tdata[21:20] == scfla_pkg::ST_BADSIZE))
    else $error("undefined result code");

endmodule

`default_nettype wire

// ===== rtl/core/scfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// scfla_ctrl: allocator sequencer
// One-hot state machine that walks each request through decode, list access,
// chunk sizing, node linking and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module scfla_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  input  wire scfla_pkg::stat_t stat_i,
  output scfla_pkg::cmd_t       cmd_o
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_DECODE  = 10'b00_0000_0100,
    S_HEAD    = 10'b00_0000_1000,
    S_COUNT   = 10'b00_0001_0000,
    S_FIT     = 10'b00_0010_0000,
    S_LINKW   = 10'b00_0100_0000,
    S_LINK_RD = 10'b00_1000_0000,
    S_LINK    = 10'b01_0000_0000,
    S_RESULT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.bad_size) begin
          cmd_o.set_code = 1'b1;
          cmd_o.code     = scfla_pkg::ST_BADSIZE;
          state_d        = S_RESULT;
        end else begin
          cmd_o.cls_rd = 1'b1;
          state_d      = S_HEAD;
        end
      end
      S_HEAD: begin
        if (stat_i.is_free) begin
          cmd_o.free_wr  = stat_i.free_in_arena;
          cmd_o.set_code = 1'b1;
          cmd_o.code     = scfla_pkg::ST_OK;
          state_d        = S_RESULT;
        end else if (stat_i.head_valid) begin
          cmd_o.take_head = 1'b1;
          state_d         = S_LINK_RD;
        end else begin
          cmd_o.count_init = 1'b1;
          state_d          = S_COUNT;
        end
      end
      S_COUNT: begin
        if (stat_i.count_done) begin
          state_d = S_FIT;
        end else begin
          cmd_o.count_step = 1'b1;
        end
      end
      S_FIT: begin
        if (stat_i.fits) begin
          cmd_o.carve_start = 1'b1;
          state_d           = S_LINKW;
        end else begin
          cmd_o.set_code = 1'b1;
          cmd_o.code     = scfla_pkg::ST_NOMEM;
          state_d        = S_RESULT;
        end
      end
      S_LINKW: begin
        cmd_o.link_wr = 1'b1;
        if (stat_i.last_node) begin
          state_d = S_LINK_RD;
        end
      end
      S_LINK_RD: begin
        cmd_o.link_rd = 1'b1;
        state_d       = S_LINK;
      end
      S_LINK: begin
        cmd_o.pop_wr   = 1'b1;
        cmd_o.set_code = 1'b1;
        cmd_o.code     = scfla_pkg::ST_OK;
        state_d        = S_RESULT;
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/scfla_dp.sv =====
// ----------------------------------------------------------------------------
// scfla_dp: allocator datapath
// Class head memory, block link memory, arena bump pointer, chunk sizing
// accumulator, node linking counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scfla_dp #(
  parameter int ALIGN_BYTES       = 8,
  parameter int NODES_PER_CHUNK   = 64,
  parameter int CHUNK_LIMIT_BYTES = 16385,
  parameter int NUM_CLASSES       = 2048,
  parameter int ARENA_BYTES       = 1048576
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire scfla_pkg::cmd_t  cmd_i,
  output scfla_pkg::stat_t      stat_o,
  input  wire logic             req_op_i,
  input  wire logic [15:0]      req_bytes_i,
  input  wire logic [19:0]      req_addr_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output logic [19:0]           res_grant_o,
  output logic [1:0]            res_status_o
);

  localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
  localparam int CLS_W    = $clog2(NUM_CLASSES);
  localparam int BLK_CNT  = ARENA_BYTES / ALIGN_BYTES;
  localparam int BLK_W    = $clog2(BLK_CNT);
  localparam int TOP_W    = $clog2(ARENA_BYTES + 1);
  localparam int MAX_REQ  = NUM_CLASSES * ALIGN_BYTES;
  localparam int SUM_W    = $clog2(ARENA_BYTES + CHUNK_LIMIT_BYTES + MAX_REQ + 1);
  localparam int CNT_W    = $clog2(NODES_PER_CHUNK + 1);

  // Request capture.
  logic        op_q;
  logic [15:0] bytes_q;
  logic [19:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= req_op_i;
      bytes_q <= req_bytes_i;
      addr_q  <= req_addr_i;
    end
  end

  logic [31:0]      bytes_m1;
  logic [31:0]      addr_ext;
  logic [CLS_W-1:0] cls;
  logic [BLK_W-1:0] free_blk;

  assign bytes_m1 = 32'(bytes_q) - 32'd1;
  assign cls      = bytes_m1[ALIGN_SH +: CLS_W];
  assign addr_ext = 32'(addr_q);
  assign free_blk = addr_ext[ALIGN_SH +: BLK_W];

  // Class head memory: valid flag in the top bit, block index below.
  logic [BLK_W:0] class_mem [NUM_CLASSES];
  logic [BLK_W:0] head_rd_q;
  logic           cm_we;
  logic [CLS_W-1:0] cm_waddr;
  logic [BLK_W:0] cm_wdata;
  logic [CLS_W-1:0] clr_q;

  // Block link memory: valid flag in the top bit, next block index below.
  logic [BLK_W:0] link_mem [BLK_CNT];
  logic [BLK_W:0] link_rd_q;
  logic           lm_we;
  logic [BLK_W-1:0] lm_waddr;
  logic [BLK_W:0] lm_wdata;

  // Chunk sizing and carving.
  logic [TOP_W-1:0] arena_top_q;
  logic [SUM_W-1:0] node_q;
  logic [SUM_W-1:0] acc_q;
  logic [SUM_W-1:0] acc_nxt;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] rem_q;
  logic [CLS_W:0]   step_q;
  logic [BLK_W-1:0] here_q;
  logic [BLK_W-1:0] here_nxt;
  logic [BLK_W-1:0] first_blk;
  logic [BLK_W-1:0] pop_blk_q;
  logic [31:0]      top_ext;
  logic [31:0]      grant_ext;
  logic [19:0]      grant_q;
  logic [1:0]       code_q;

  logic             res_valid_q;
  logic [19:0]      res_grant_q;
  logic [1:0]       res_status_q;

  assign top_ext   = 32'(arena_top_q);
  assign first_blk = top_ext[ALIGN_SH +: BLK_W];
  assign acc_nxt   = acc_q + node_q;
  assign here_nxt  = here_q + BLK_W'(step_q);
  assign grant_ext = 32'(pop_blk_q) << ALIGN_SH;

  // Class memory write port.
  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = cls;
    cm_wdata = '0;
    if (cmd_i.clear_step) begin
      cm_we    = 1'b1;
      cm_waddr = clr_q;
    end else if (cmd_i.free_wr) begin
      cm_we    = 1'b1;
      cm_wdata = {1'b1, free_blk};
    end else if (cmd_i.pop_wr) begin
      cm_we    = 1'b1;
      cm_wdata = link_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      class_mem[cm_waddr] <= cm_wdata;
    end
    if (cmd_i.cls_rd) begin
      head_rd_q <= class_mem[cls];
    end
  end

  // Link memory write port.
  always_comb begin
    lm_we    = 1'b0;
    lm_waddr = here_q;
    lm_wdata = '0;
    if (cmd_i.free_wr) begin
      lm_we    = 1'b1;
      lm_waddr = free_blk;
      lm_wdata = head_rd_q[BLK_W] ? head_rd_q : '0;
    end else if (cmd_i.link_wr) begin
      lm_we    = 1'b1;
      lm_wdata = (rem_q == CNT_W'(1)) ? '0 : {1'b1, here_nxt};
    end
  end

  always_ff @(posedge clk_i) begin
    if (lm_we) begin
      link_mem[lm_waddr] <= lm_wdata;
    end
    if (cmd_i.link_rd) begin
      link_rd_q <= link_mem[pop_blk_q];
    end
  end

  // Clear sweep counter and arena bump pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      arena_top_q <= '0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + CLS_W'(1);
      end
      if (cmd_i.carve_start) begin
        arena_top_q <= arena_top_q + TOP_W'(acc_q);
      end
    end
  end

  // Sizing, linking and pop registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.count_init) begin
      node_q <= (SUM_W'(cls) + SUM_W'(1)) << ALIGN_SH;
      acc_q  <= (SUM_W'(cls) + SUM_W'(1)) << ALIGN_SH;
      step_q <= (CLS_W + 1)'(cls) + (CLS_W + 1)'(1);
      cnt_q  <= CNT_W'(1);
    end else if (cmd_i.count_step) begin
      acc_q <= acc_nxt;
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.carve_start) begin
      here_q    <= first_blk;
      rem_q     <= cnt_q;
      pop_blk_q <= first_blk;
    end else if (cmd_i.link_wr) begin
      here_q <= here_nxt;
      rem_q  <= rem_q - CNT_W'(1);
    end else if (cmd_i.take_head) begin
      pop_blk_q <= head_rd_q[BLK_W-1:0];
    end
    if (cmd_i.pop_wr) begin
      grant_q <= grant_ext[19:0];
    end
    if (cmd_i.set_code) begin
      code_q <= cmd_i.code;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= code_q;
      res_grant_q  <= (code_q == scfla_pkg::ST_OK && op_q == scfla_pkg::OP_ALLOC)
                      ? grant_q : '0;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_grant_o  = res_grant_q;
  assign res_status_o = res_status_q;

  // Status back to the controller.
  always_comb begin
    stat_o               = '0;
    stat_o.clear_done    = (clr_q == CLS_W'(NUM_CLASSES - 1));
    stat_o.bad_size      = (bytes_q == 16'd0) || (32'(bytes_q) > 32'(MAX_REQ));
    stat_o.is_free       = (op_q == scfla_pkg::OP_FREE);
    stat_o.free_in_arena = (addr_ext < 32'(ARENA_BYTES));
    stat_o.head_valid    = head_rd_q[BLK_W];
    stat_o.count_done    = (cnt_q >= CNT_W'(NODES_PER_CHUNK))
                           || (acc_nxt > SUM_W'(CHUNK_LIMIT_BYTES));
    stat_o.fits          = (SUM_W'(arena_top_q) + acc_q) <= SUM_W'(ARENA_BYTES);
    stat_o.last_node     = (rem_q == CNT_W'(1));
    stat_o.out_free      = !res_valid_q || res_ready_i;
  end

endmodule

`default_nettype wire

// ===== tb/allocator_checker.sv =====
// ----------------------------------------------------------------------------
// allocator_checker: predictor and scoreboard for the free list allocator
// Watches the request and result channels. It keeps its own copy of the class
// lists, the block links and the arena top, and checks every result word in
// order against the reply that it worked out for the matching request.
// ----------------------------------------------------------------------------
module allocator_checker
  import scfla_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [39:0] req_data_i,   // [15:0] request_bytes, [35:16] block_address
  input  logic [0:0]  req_user_i,   // [0] operation
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [23:0] res_data_i,   // [19:0] granted_address, [21:20] status
  output int          fail_count_o,
  output int          pending_o,
  output int          grants_o,
  output int          frees_o,
  output int          chunks_o,
  output int          nomem_o,
  output int          badsize_o
);

  localparam int unsigned GRAIN      = 8;
  localparam int unsigned CHUNK_CAP  = 16385;
  localparam int unsigned NODE_CAP   = 64;
  localparam int unsigned CLASSES    = 2048;
  localparam int unsigned ARENA_SIZE = 1048576;
  localparam int unsigned BLOCKS     = ARENA_SIZE / GRAIN;
  localparam int unsigned MAX_BYTES  = CLASSES * GRAIN;

  typedef struct packed {
    logic [19:0] granted;
    status_e     status;
  } reply_t;

  bit          list_live  [CLASSES];
  bit   [16:0] list_head  [CLASSES];
  bit   [17:0] next_block [BLOCKS];  // [17] link valid, [16:0] next block index
  int unsigned arena_top;

  reply_t due_replies [$];
  int     fail_count, grants, frees, chunks, nomem, badsize;

  // Works out the reply to one request and updates the lists as the block would.
  function automatic reply_t serve_request(op_e op, logic [15:0] bytes,
                                           logic [19:0] addr);
    reply_t      r;
    int unsigned cls, node_bytes, node_count, first, stride, here, blk;
    r.granted = '0;
    r.status  = ST_OK;
    if (bytes == 0 || bytes > MAX_BYTES) begin
      r.status = ST_BADSIZE;
      badsize++;
      return r;
    end
    cls = (bytes - 1) / GRAIN;

    if (op == OP_FREE) begin
      // The low address bits are dropped and the block is pushed unchecked.
      blk = addr / GRAIN;
      next_block[blk] = list_live[cls] ? {1'b1, list_head[cls]} : 18'd0;
      list_head[cls]  = 17'(blk);
      list_live[cls]  = 1'b1;
      frees++;
      return r;
    end

    if (!list_live[cls]) begin
      node_bytes = (cls + 1) * GRAIN;
      node_count = CHUNK_CAP / node_bytes;
      if (node_count > NODE_CAP) node_count = NODE_CAP;
      if (node_count == 0) node_count = 1;
      // A chunk is carved whole or not at all.
      if (arena_top + node_count * node_bytes > ARENA_SIZE) begin
        r.status = ST_NOMEM;
        nomem++;
        return r;
      end
      first  = arena_top / GRAIN;
      stride = cls + 1;
      for (int unsigned k = 0; k < node_count; k++) begin
        here = first + k * stride;
        if (k + 1 < node_count) begin
          next_block[here] = {1'b1, 17'(here + stride)};
        end else begin
          next_block[here] = '0;
        end
      end
      list_head[cls] = 17'(first);
      list_live[cls] = 1'b1;
      arena_top += node_count * node_bytes;
      chunks++;
    end

    blk = list_head[cls];
    list_live[cls] = next_block[blk][17];
    list_head[cls] = next_block[blk][16:0];
    r.granted = 20'(blk * GRAIN);
    grants++;
    return r;
  endfunction

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 25) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    reply_t      want;
    logic [19:0] got_addr;
    logic [1:0]  got_status;
    if (!rst_ni) begin
      for (int i = 0; i < CLASSES; i++) list_live[i] = 1'b0;
      arena_top = 0;
      due_replies.delete();
    end else begin
      // A request taken at this edge is predicted before any result of this
      // edge is checked; a result never belongs to a request of the same edge.
      if (req_valid_i && req_ready_i) begin
        due_replies.push_back(serve_request(op_e'(req_user_i[0]), req_data_i[15:0],
                                            req_data_i[35:16]));
      end
      if (res_valid_i && res_ready_i) begin
        got_addr   = res_data_i[19:0];
        got_status = res_data_i[21:20];
        if (due_replies.size() == 0) begin
          report($sformatf("result word %h arrived with nothing expected", res_data_i));
        end else begin
          want = due_replies.pop_front();
          if (got_addr !== want.granted) begin
            report($sformatf("granted_address expected %h, got %h", want.granted, got_addr));
          end
          if (got_status !== want.status) begin
            report($sformatf("status expected %0d, got %0d", want.status, got_status));
          end
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= due_replies.size();
    grants_o     <= grants;
    frees_o      <= frees;
    chunks_o     <= chunks;
    nomem_o      <= nomem;
    badsize_o    <= badsize;
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top of the size class free list allocator test
// Drives directed and random allocate and free requests with bursty traffic
// and a stalling receiver, and lets the checker judge every result word.
// ----------------------------------------------------------------------------
module testbench;
  import scfla_pkg::*;

  // The slowest legal run is far below this: about 600 words, each at most a
  // chunk refill plus a sender gap and a receiver stall, after the sweep of
  // the class heads that follows reset.
  localparam int unsigned CYCLE_LIMIT   = 500_000;
  localparam int unsigned WARMUP_ITEMS  = 400;
  localparam int unsigned SQUEEZE_ITEMS = 150;

  typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_pattern_e;

  typedef struct {
    op_e         op;
    logic [15:0] bytes;
  } request_t;

  typedef struct {
    logic [19:0] addr;
    logic [15:0] bytes;
  } live_block_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // [15:0] request_bytes, [35:16] block_address
  logic [0:0]  s_axis_tuser  = '0;  // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [19:0] granted_address, [21:20] status

  int          fail_count, pending, grants, frees, chunks, nomem, badsize;
  request_t    issued [$];       // requests whose result word is still to come
  live_block_t live_blocks [$];  // granted blocks that may be handed back
  int unsigned burst_left = 0;
  int unsigned sent       = 0;
  int unsigned cycle      = 0;
  rx_pattern_e rx_mode    = RX_OPEN;

  size_class_free_list_allocator_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  allocator_checker grant_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_user_i  (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .grants_o    (grants),
    .frees_o     (frees),
    .chunks_o    (chunks),
    .nomem_o     (nomem),
    .badsize_o   (badsize)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d result words still due", cycle, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver switches between stall patterns drawn at random: always
  // ready, randomly ready, ready one cycle in four, and long stalls broken by
  // short open windows.
  always @(posedge clk_i) begin
    if (cycle % 97 == 0) rx_mode <= rx_pattern_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: m_axis_tready <= (cycle % 4 == 0);
      default:   m_axis_tready <= (cycle % 13 < 3);
    endcase
  end

  // Every granted block goes into the pool that the random part frees from,
  // so most frees hand back a block that really is in use.
  always @(posedge clk_i) begin : grant_pool
    request_t req;
    if (m_axis_tvalid && m_axis_tready && issued.size() > 0) begin
      req = issued.pop_front();
      if (req.op == OP_ALLOC && status_e'(m_axis_tdata[21:20]) == ST_OK) begin
        live_blocks.push_back('{m_axis_tdata[19:0], req.bytes});
      end
    end
  end

  // Sends one request word. The sender works in bursts: when a burst runs
  // out, valid drops for a random gap and a new burst length is drawn, with
  // an occasional long burst so that some stretches run without gaps.
  task automatic send_word(input op_e op, input logic [15:0] bytes,
                           input logic [19:0] addr);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, addr, bytes};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    issued.push_back('{op, bytes});
    burst_left--;
    sent++;
  endtask

  // Holds the sender off until every result word has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    burst_left = 0;
  endtask

  // Mostly small sizes unless large_pct is high; medium and large ones open
  // fresh classes that each carve up to 16 KiB and drive the arena to its end.
  function automatic logic [15:0] pick_size(input int unsigned large_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < large_pct) return 16'($urandom_range(2049, 16384));
    if (roll < large_pct + 8) return 16'($urandom_range(257, 2048));
    return 16'($urandom_range(1, 256));
  endfunction

  task automatic random_item(input int unsigned large_pct, input int unsigned free_pct);
    int unsigned roll, pick;
    live_block_t blk;
    logic [15:0] bytes;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      // Size out of range on either operation.
      bytes = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(16385, 65535));
      send_word(op_e'($urandom_range(0, 1)), bytes, 20'($urandom));
    end else if (roll < 10) begin
      // Free of an arbitrary address, in use or not.
      send_word(OP_FREE, pick_size(large_pct), 20'($urandom));
    end else if (live_blocks.size() > 0 &&
                 (roll < 10 + free_pct || live_blocks.size() > 80)) begin
      pick = $urandom_range(0, live_blocks.size() - 1);
      blk  = live_blocks[pick];
      roll = $urandom_range(0, 99);
      // A double free leaves the block in the pool so it can come back again.
      if (roll >= 6) live_blocks.delete(pick);
      if (roll >= 6 && roll < 12) begin
        blk.addr |= 20'($urandom_range(1, 7));
      end else if (roll >= 12 && roll < 18) begin
        blk.bytes = pick_size(0);
      end
      send_word(OP_FREE, blk.bytes, blk.addr);
    end else begin
      send_word(OP_ALLOC, pick_size(large_pct), 20'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The first allocate of a class refills it; the largest
    // size makes one-node chunks; the same class refills twice in a row.
    send_word(OP_ALLOC, 16'd1, 20'd0);
    send_word(OP_ALLOC, 16'd8, 20'hFFFFF);
    send_word(OP_ALLOC, 16'd9, 20'd0);
    send_word(OP_ALLOC, 16'd16384, 20'd0);
    send_word(OP_ALLOC, 16'd16384, 20'd0);
    // Bad sizes on both operations, with both extremes of the address.
    send_word(OP_ALLOC, 16'd0, 20'd0);
    send_word(OP_ALLOC, 16'd16385, 20'd0);
    send_word(OP_ALLOC, 16'hFFFF, 20'hFFFFF);
    send_word(OP_FREE, 16'd0, 20'd0);
    send_word(OP_FREE, 16'hFFFF, 20'hFFFFF);
    // An unaligned free of the top block of the address space, then its reuse.
    send_word(OP_FREE, 16'd8, 20'hFFFFF);
    send_word(OP_ALLOC, 16'd8, 20'd0);
    // A double free hands the same block out twice.
    send_word(OP_FREE, 16'd8, 20'h00010);
    send_word(OP_FREE, 16'd8, 20'h00010);
    send_word(OP_ALLOC, 16'd5, 20'd0);
    send_word(OP_ALLOC, 16'd5, 20'd0);
    send_word(OP_ALLOC, 16'd5, 20'd0);
    // A free with the wrong size lands on the list of that other class.
    send_word(OP_FREE, 16'd200, 20'h00008);
    send_word(OP_ALLOC, 16'd200, 20'd0);
    send_word(OP_FREE, 16'd16384, 20'd0);
    send_word(OP_ALLOC, 16'd16384, 20'd0);
    // The last class with a full 64-node chunk and the first with fewer.
    send_word(OP_ALLOC, 16'd256, 20'd0);
    send_word(OP_ALLOC, 16'd257, 20'd0);
    drain_results();

    // Random part: first mostly small blocks with plenty of frees, then a
    // stretch heavy on large allocates that runs the arena dry.
    repeat (WARMUP_ITEMS) random_item(2, 40);
    drain_results();
    repeat (SQUEEZE_ITEMS) random_item(60, 25);
    drain_results();
    repeat (200) @(posedge clk_i);

    $display("%0d requests: %0d blocks granted, %0d frees, %0d chunks carved",
             sent, grants, frees, chunks);
    $display("%0d allocates refused for lack of arena, %0d requests with a bad size",
             nomem, badsize);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/scfla_pkg.sv
rtl/core/scfla_ctrl.sv
rtl/core/scfla_dp.sv
rtl/core/size_class_free_list_allocator_unit.sv
tb/allocator_checker.sv
tb/testbench.sv
